// ----- hw/rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and the code point width classifier for the
// text column width and elide block.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int CU_W     = 16;
	localparam int CP_W     = 21;
	localparam int MW_W     = 12;
	localparam int TW_W     = 17;
	localparam int Q_DEPTH  = 2;

	localparam logic [MW_W-1:0] MAX_WIDTH_RST = 12'd80;
	localparam logic [TW_W-1:0] WIDTH_CAP     = 17'd131070;

	localparam logic [CU_W-1:0] HIGH_LO = 16'hD800;
	localparam logic [CU_W-1:0] HIGH_HI = 16'hDBFF;
	localparam logic [CU_W-1:0] LOW_LO  = 16'hDC00;
	localparam logic [CU_W-1:0] LOW_HI  = 16'hDFFF;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	// one queue transaction: an optional flushed high surrogate (a) followed
	// by an optional code point completed by the current unit (b)
	typedef struct packed {
		logic       a_valid;
		logic [1:0] a_width;
		logic       b_valid;
		logic [1:0] b_width;
		logic       b_pair;
		logic       last;
	} cp_entry_t;

	typedef struct packed {
		logic [TW_W-1:0] run_width;
		logic [MW_W-1:0] pre_width;
		logic [CU_W-1:0] pre_units;
		logic            pre_closed;
		logic [CU_W-1:0] tot_units;
	} str_state_t;

	function automatic logic in_span(input logic [CP_W-1:0] cp,
		input logic [CP_W-1:0] lo, input logic [CP_W-1:0] hi);
		in_span = (cp >= lo) && (cp <= hi);
	endfunction

	function automatic logic [1:0] cp_width(input logic [CP_W-1:0] cp);
		logic zero_w;
		logic wide_w;
		zero_w = (cp == '0)
			|| in_span(cp, 21'h0300, 21'h036F) || in_span(cp, 21'h200B, 21'h200F)
			|| in_span(cp, 21'hFE00, 21'hFE0F) || in_span(cp, 21'hFE20, 21'hFE2F)
			|| in_span(cp, 21'hFEFF, 21'hFEFF);
		wide_w = in_span(cp, 21'h1100, 21'h115F) || in_span(cp, 21'h2E80, 21'h303E)
			|| in_span(cp, 21'h3041, 21'h33FF) || in_span(cp, 21'h3400, 21'h4DBF)
			|| in_span(cp, 21'h4E00, 21'h9FFF) || in_span(cp, 21'hA000, 21'hA4CF)
			|| in_span(cp, 21'hAC00, 21'hD7A3) || in_span(cp, 21'hF900, 21'hFAFF)
			|| in_span(cp, 21'hFE10, 21'hFE19) || in_span(cp, 21'hFE30, 21'hFE6F)
			|| in_span(cp, 21'hFF00, 21'hFF60) || in_span(cp, 21'hFFE0, 21'hFFE6)
			|| in_span(cp, 21'h1F000, 21'h1F0FF) || in_span(cp, 21'h1F300, 21'h1F64F)
			|| in_span(cp, 21'h1F900, 21'h1F9FF) || in_span(cp, 21'h20000, 21'h3FFFD);
		if (zero_w) begin
			cp_width = 2'd0;
		end else if (wide_w) begin
			cp_width = 2'd2;
		end else begin
			cp_width = 2'd1;
		end
	endfunction

endpackage

// ----- hw/rtl/text_column_width_and_elide.sv -----
`timescale 1ns / 1ps
// With the queue empty, a transaction with last set is registered in the queue, and its result is
// then registered in the result register, which holds it while out_ready is low.
// Throughput: one code unit per cycle while the queue is not full, set by the single accumulate step in the back part.
// A two-entry queue lets input continue while a result waits in the output register.
// Reset (arst_n low, asynchronous): string state cleared, queue empty, max_width = 80.
// ----------------------------------------------------------------------------
// text_column_width_and_elide
// Terminal column width and elision of a UTF-16 string, one code unit per cycle while in_ready is high.
// ----------------------------------------------------------------------------
module text_column_width_and_elide #(
	parameter int MAX_UNITS = 65535
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tcw_pkg::MW_W-1:0]  cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [tcw_pkg::CU_W-1:0]  code_unit,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [tcw_pkg::TW_W-1:0]  total_width,
	output logic                      fits,
	output logic [tcw_pkg::CU_W-1:0]  keep_units,
	output logic                      ellipsis,
	output logic [tcw_pkg::MW_W-1:0]  fitted_width,
	output logic [tcw_pkg::MW_W-1:0]  pad_columns
);

	logic [tcw_pkg::MW_W-1:0] max_width_q;
	logic                     q_push;
	logic                     q_push_ready;
	logic                     q_pop;
	logic                     q_valid;
	tcw_pkg::cp_entry_t       q_in;
	tcw_pkg::cp_entry_t       q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q <= tcw_pkg::MAX_WIDTH_RST;
		end else if (cfg_we) begin
			max_width_q <= cfg_wdata;
		end
	end

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_unit (code_unit),
		.last      (last),
		.q_ready   (q_push_ready),
		.q_push    (q_push),
		.q_entry   (q_in)
	);

	tcw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.push_ready (q_push_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_entry  (q_out)
	);

	tcw_back #(
		.MAX_UNITS (MAX_UNITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_width    (max_width_q),
		.q_valid      (q_valid),
		.q_entry      (q_out),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.total_width  (total_width),
		.fits         (fits),
		.keep_units   (keep_units),
		.ellipsis     (ellipsis),
		.fitted_width (fitted_width),
		.pad_columns  (pad_columns)
	);

endmodule

// ----- hw/rtl/tcw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts code units, pairs surrogates and classifies code point widths.
// ----------------------------------------------------------------------------
module tcw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tcw_pkg::CU_W-1:0]      code_unit,
	input  logic                          last,
	input  logic                          q_ready,
	output logic                          q_push,
	output tcw_pkg::cp_entry_t            q_entry
);

	logic                     pend_q;
	logic [tcw_pkg::CU_W-1:0] held_q;
	logic                     is_high;
	logic                     is_low;
	logic                     pair;
	logic                     accept;
	logic [tcw_pkg::CP_W-1:0] pair_cp;

	assign in_ready = q_ready;
	assign accept   = in_valid & q_ready;
	assign q_push   = accept;

	assign is_high = (code_unit >= tcw_pkg::HIGH_LO) && (code_unit <= tcw_pkg::HIGH_HI);
	assign is_low  = (code_unit >= tcw_pkg::LOW_LO) && (code_unit <= tcw_pkg::LOW_HI);
	assign pair    = pend_q & is_low;
	assign pair_cp = tcw_pkg::SUPP_BASE + {1'b0, held_q[9:0], code_unit[9:0]};

	always_comb begin
		q_entry.a_valid = pend_q & ~is_low;
		q_entry.a_width = tcw_pkg::cp_width({5'd0, held_q});
		q_entry.b_valid = pair | ~(is_high & ~last);
		q_entry.b_width = pair ? tcw_pkg::cp_width(pair_cp)
			: tcw_pkg::cp_width({5'd0, code_unit});
		q_entry.b_pair  = pair;
		q_entry.last    = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			held_q <= '0;
		end else if (accept) begin
			pend_q <= ~pair & is_high & ~last;
			if (~pair & is_high & ~last) begin
				held_q <= code_unit;
			end
		end
	end

endmodule

// ----- hw/rtl/tcw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue
// Short FIFO between the front and the back part.
// ----------------------------------------------------------------------------
module tcw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tcw_pkg::cp_entry_t push_entry,
	output logic               push_ready,
	input  logic               pop,
	output logic               pop_valid,
	output tcw_pkg::cp_entry_t pop_entry
);

	localparam int PW = (tcw_pkg::Q_DEPTH > 1) ? $clog2(tcw_pkg::Q_DEPTH) : 1;
	localparam int CW = $clog2(tcw_pkg::Q_DEPTH + 1);

	tcw_pkg::cp_entry_t mem_q [tcw_pkg::Q_DEPTH];
	logic [PW-1:0]      wr_q;
	logic [PW-1:0]      rd_q;
	logic [CW-1:0]      cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != CW'(tcw_pkg::Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = mem_q[rd_q];
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		nxt = (p == PW'(tcw_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= nxt(wr_q);
			end
			if (do_pop) begin
				rd_q <= nxt(rd_q);
			end
			if (do_push & ~do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop & ~do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/tcw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Accumulates widths and the fitted prefix, forms the result per string.
// ----------------------------------------------------------------------------
module tcw_back #(
	parameter int MAX_UNITS = 65535
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [tcw_pkg::MW_W-1:0]  max_width,
	input  logic                      q_valid,
	input  tcw_pkg::cp_entry_t        q_entry,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [tcw_pkg::TW_W-1:0]  total_width,
	output logic                      fits,
	output logic [tcw_pkg::CU_W-1:0]  keep_units,
	output logic                      ellipsis,
	output logic [tcw_pkg::MW_W-1:0]  fitted_width,
	output logic [tcw_pkg::MW_W-1:0]  pad_columns
);

	localparam logic [tcw_pkg::CU_W:0] UNIT_CAP = (tcw_pkg::CU_W + 1)'(MAX_UNITS);

	tcw_pkg::str_state_t st_q;
	tcw_pkg::str_state_t st_a;
	tcw_pkg::str_state_t st_b;
	logic [tcw_pkg::MW_W-1:0] budget;
	logic                     out_valid_q;
	logic [tcw_pkg::TW_W-1:0] tw_q;
	logic                     fits_q;
	logic [tcw_pkg::CU_W-1:0] keep_q;
	logic                     ell_q;
	logic [tcw_pkg::MW_W-1:0] fitted_q;
	logic [tcw_pkg::MW_W-1:0] pad_q;
	logic                     r_fits;
	logic [tcw_pkg::CU_W-1:0] r_keep;
	logic                     r_ell;
	logic [tcw_pkg::MW_W-1:0] r_fitted;
	logic [tcw_pkg::MW_W-1:0] r_pad;

	function automatic logic [tcw_pkg::CU_W-1:0] sat_units(
		input logic [tcw_pkg::CU_W-1:0] a, input logic [1:0] u);
		logic [tcw_pkg::CU_W:0] s;
		s = {1'b0, a} + {{(tcw_pkg::CU_W - 1){1'b0}}, u};
		sat_units = (s > UNIT_CAP) ? UNIT_CAP[tcw_pkg::CU_W-1:0] : s[tcw_pkg::CU_W-1:0];
	endfunction

	function automatic tcw_pkg::str_state_t take(input tcw_pkg::str_state_t s,
		input logic [1:0] w, input logic [1:0] u, input logic [tcw_pkg::MW_W-1:0] b);
		tcw_pkg::str_state_t    r;
		logic [tcw_pkg::TW_W:0] rw;
		logic [tcw_pkg::MW_W:0] pw;
		r  = s;
		rw = {1'b0, s.run_width} + {{(tcw_pkg::TW_W - 1){1'b0}}, w};
		r.run_width = (rw > {1'b0, tcw_pkg::WIDTH_CAP}) ? tcw_pkg::WIDTH_CAP
			: rw[tcw_pkg::TW_W-1:0];
		r.tot_units = sat_units(s.tot_units, u);
		pw = {1'b0, s.pre_width} + {{(tcw_pkg::MW_W - 1){1'b0}}, w};
		if (!s.pre_closed) begin
			if (pw > {1'b0, b}) begin
				r.pre_closed = 1'b1;
			end else begin
				r.pre_width = pw[tcw_pkg::MW_W-1:0];
				r.pre_units = sat_units(s.pre_units, u);
			end
		end
		take = r;
	endfunction

	assign budget = (max_width == '0) ? '0 : max_width - 1'b1;
	assign q_pop  = q_valid & (~out_valid_q | out_ready);

	always_comb begin
		st_a = q_entry.a_valid ? take(st_q, q_entry.a_width, 2'd1, budget) : st_q;
		st_b = q_entry.b_valid
			? take(st_a, q_entry.b_width, q_entry.b_pair ? 2'd2 : 2'd1, budget) : st_a;
	end

	always_comb begin
		r_fits   = 1'b0;
		r_keep   = '0;
		r_ell    = 1'b0;
		r_fitted = '0;
		r_pad    = '0;
		if (max_width == '0) begin
			r_fits = 1'b0;
		end else if (st_b.run_width <= {5'd0, max_width}) begin
			r_fits   = 1'b1;
			r_keep   = st_b.tot_units;
			r_fitted = st_b.run_width[tcw_pkg::MW_W-1:0];
			r_pad    = max_width - st_b.run_width[tcw_pkg::MW_W-1:0];
		end else if (max_width == 12'd1) begin
			r_ell    = 1'b1;
			r_fitted = 12'd1;
		end else begin
			r_keep   = st_b.pre_units;
			r_ell    = 1'b1;
			r_fitted = st_b.pre_width + 1'b1;
			r_pad    = max_width - (st_b.pre_width + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				st_q <= q_entry.last ? '0 : st_b;
			end
			if (q_pop & q_entry.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop & q_entry.last) begin
			tw_q     <= st_b.run_width;
			fits_q   <= r_fits;
			keep_q   <= r_keep;
			ell_q    <= r_ell;
			fitted_q <= r_fitted;
			pad_q    <= r_pad;
		end
	end

	assign out_valid    = out_valid_q;
	assign total_width  = tw_q;
	assign fits         = fits_q;
	assign keep_units   = keep_q;
	assign ellipsis     = ell_q;
	assign fitted_width = fitted_q;
	assign pad_columns  = pad_q;

endmodule

// ----- tb/text_width_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_width_checker
// Follows the code unit, report and register traffic of the column width
// block, keeps its own copy of the string state and checks every report,
// field by field, against the oldest report still due.
// ----------------------------------------------------------------------------
module text_width_checker #(
	parameter int MAX_UNITS = 65535
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tcw_pkg::MW_W-1:0] cfg_wdata,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [tcw_pkg::CU_W-1:0] code_unit,
	input  logic                     last,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [tcw_pkg::TW_W-1:0] total_width,
	input  logic                     fits,
	input  logic [tcw_pkg::CU_W-1:0] keep_units,
	input  logic                     ellipsis,
	input  logic [tcw_pkg::MW_W-1:0] fitted_width,
	input  logic [tcw_pkg::MW_W-1:0] pad_columns,
	output int                       mismatch_count,
	output int                       reports_due
);

	typedef logic [tcw_pkg::TW_W-1:0] tw_t;
	typedef logic [tcw_pkg::CU_W-1:0] cu_t;
	typedef logic [tcw_pkg::MW_W-1:0] mw_t;

	typedef struct {
		logic [tcw_pkg::TW_W-1:0] total_width;
		logic                     fits;
		logic [tcw_pkg::CU_W-1:0] keep_units;
		logic                     ellipsis;
		logic [tcw_pkg::MW_W-1:0] fitted_width;
		logic [tcw_pkg::MW_W-1:0] pad_columns;
	} width_report_t;

	width_report_t due_reports[$];

	logic [tcw_pkg::MW_W-1:0] max_width;
	logic                     high_held;
	logic [tcw_pkg::CU_W-1:0] held_unit;
	int unsigned              string_width;
	int unsigned              string_units;
	int unsigned              prefix_width;
	int unsigned              prefix_units;
	logic                     prefix_closed;

	function automatic int unsigned columns_of(input int unsigned cp);
		if (cp == 0) begin
			return 0;
		end
		if ((cp >= 32'h0300 && cp <= 32'h036F) || (cp >= 32'h200B && cp <= 32'h200F)
			|| (cp >= 32'hFE00 && cp <= 32'hFE0F) || (cp >= 32'hFE20 && cp <= 32'hFE2F)
			|| cp == 32'hFEFF) begin
			return 0;
		end
		if ((cp >= 32'h1100 && cp <= 32'h115F) || (cp >= 32'h2E80 && cp <= 32'h303E)
			|| (cp >= 32'h3041 && cp <= 32'h4DBF) || (cp >= 32'h4E00 && cp <= 32'h9FFF)
			|| (cp >= 32'hA000 && cp <= 32'hA4CF) || (cp >= 32'hAC00 && cp <= 32'hD7A3)
			|| (cp >= 32'hF900 && cp <= 32'hFAFF) || (cp >= 32'hFE10 && cp <= 32'hFE19)
			|| (cp >= 32'hFE30 && cp <= 32'hFE6F) || (cp >= 32'hFF00 && cp <= 32'hFF60)
			|| (cp >= 32'hFFE0 && cp <= 32'hFFE6) || (cp >= 32'h1F000 && cp <= 32'h1F0FF)
			|| (cp >= 32'h1F300 && cp <= 32'h1F64F) || (cp >= 32'h1F900 && cp <= 32'h1F9FF)
			|| (cp >= 32'h20000 && cp <= 32'h3FFFD)) begin
			return 2;
		end
		return 1;
	endfunction

	function automatic int unsigned capped_units(input int unsigned a, input int unsigned b);
		return (a + b > MAX_UNITS) ? MAX_UNITS : a + b;
	endfunction

	function automatic void restart_string();
		high_held = 1'b0;
		held_unit = '0;
		string_width = 0;
		string_units = 0;
		prefix_width = 0;
		prefix_units = 0;
		prefix_closed = 1'b0;
	endfunction

	function automatic void absorb_code_point(input int unsigned cp, input int unsigned units);
		int unsigned cols;
		int unsigned budget;
		cols = columns_of(cp);
		budget = (max_width == '0) ? 0 : 32'(max_width) - 1;
		string_width = string_width + cols;
		if (string_width > 32'(tcw_pkg::WIDTH_CAP)) begin
			string_width = 32'(tcw_pkg::WIDTH_CAP);
		end
		string_units = capped_units(string_units, units);
		// prefix stops growing at the first code point that overflows the budget
		if (!prefix_closed) begin
			if (prefix_width + cols > budget) begin
				prefix_closed = 1'b1;
			end else begin
				prefix_width = prefix_width + cols;
				prefix_units = capped_units(prefix_units, units);
			end
		end
	endfunction

	function automatic void take_unit(input logic [tcw_pkg::CU_W-1:0] u, input logic is_last);
		logic          is_high;
		logic          is_low;
		int unsigned   mw;
		int unsigned   hi_off;
		int unsigned   lo_off;
		width_report_t rep;
		is_high = (u >= tcw_pkg::HIGH_LO) && (u <= tcw_pkg::HIGH_HI);
		is_low = (u >= tcw_pkg::LOW_LO) && (u <= tcw_pkg::LOW_HI);
		mw = 32'(max_width);
		if (high_held && is_low) begin
			high_held = 1'b0;
			hi_off = 32'(held_unit) - 32'(tcw_pkg::HIGH_LO);
			lo_off = 32'(u) - 32'(tcw_pkg::LOW_LO);
			absorb_code_point(32'h10000 + (hi_off << 10) + lo_off, 2);
		end else begin
			if (high_held) begin
				high_held = 1'b0;
				absorb_code_point(32'(held_unit), 1);
			end
			if (is_high && !is_last) begin
				high_held = 1'b1;
				held_unit = u;
			end else begin
				absorb_code_point(32'(u), 1);
			end
		end
		if (is_last) begin
			rep.total_width = tw_t'(string_width);
			rep.fits = 1'b0;
			rep.keep_units = '0;
			rep.ellipsis = 1'b0;
			rep.fitted_width = '0;
			rep.pad_columns = '0;
			if (mw != 0) begin
				if (string_width <= mw) begin
					rep.fits = 1'b1;
					rep.keep_units = cu_t'(string_units);
					rep.fitted_width = mw_t'(string_width);
					rep.pad_columns = mw_t'(mw - string_width);
				end else if (mw == 1) begin
					rep.ellipsis = 1'b1;
					rep.fitted_width = 12'd1;
				end else begin
					rep.keep_units = cu_t'(prefix_units);
					rep.ellipsis = 1'b1;
					rep.fitted_width = mw_t'(prefix_width + 1);
					rep.pad_columns = mw_t'(mw - (prefix_width + 1));
				end
			end
			due_reports.push_back(rep);
			restart_string();
		end
	endfunction

	function automatic int field_diff(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		width_report_t want;
		int            errs;
		errs = 0;
		if (!arst_n) begin
			max_width = tcw_pkg::MAX_WIDTH_RST;
			restart_string();
			due_reports.delete();
			mismatch_count <= 0;
			reports_due <= 0;
		end else begin
			if (cfg_we) begin
				max_width = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				take_unit(code_unit, last);
			end
			if (out_valid && out_ready) begin
				if (due_reports.size() == 0) begin
					$error("report with no string pending: total_width %0d", total_width);
					errs++;
				end else begin
					want = due_reports.pop_front();
					errs += field_diff("total_width", want.total_width, total_width);
					errs += field_diff("fits", want.fits, fits);
					errs += field_diff("keep_units", want.keep_units, keep_units);
					errs += field_diff("ellipsis", want.ellipsis, ellipsis);
					errs += field_diff("fitted_width", want.fitted_width, fitted_width);
					errs += field_diff("pad_columns", want.pad_columns, pad_columns);
				end
			end
			mismatch_count <= mismatch_count + errs;
			reports_due <= due_reports.size();
		end
	end

endmodule

// ----- tb/text_column_width_and_elide_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_column_width_and_elide_tb
// Streams UTF-16 strings through the column width block: directed edge
// cases, then random strings under changing width settings and traffic
// patterns, then long strings. Checking is done by the checker.
// ----------------------------------------------------------------------------
module text_column_width_and_elide_tb;

	localparam int MAX_UNITS  = 65535;
	localparam int IDLE_LIMIT = 5000;

	typedef logic [tcw_pkg::CU_W-1:0] unit_t;
	typedef logic [tcw_pkg::MW_W-1:0] mw_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [tcw_pkg::MW_W-1:0] cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [tcw_pkg::CU_W-1:0] code_unit = '0;
	logic                     last = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [tcw_pkg::TW_W-1:0] total_width;
	logic                     fits;
	logic [tcw_pkg::CU_W-1:0] keep_units;
	logic                     ellipsis;
	logic [tcw_pkg::MW_W-1:0] fitted_width;
	logic [tcw_pkg::MW_W-1:0] pad_columns;
	int                       mismatch_count;
	int                       reports_due;

	int                       idle_pct = 10;
	int                       stall_pct = 53;
	int                       quiet_cycles = 0;
	logic [tcw_pkg::CU_W-1:0] text_buf[$];
	logic [tcw_pkg::CU_W-1:0] edge_units[0:23] = '{
		16'h0000, 16'h02FF, 16'h0300, 16'h036F, 16'h0370, 16'h10FF, 16'h1100, 16'h115F,
		16'h1160, 16'h200A, 16'h200B, 16'h200F, 16'h2010, 16'h4DBF, 16'h4DC0, 16'h4E00,
		16'h9FFF, 16'hD7A3, 16'hD7A4, 16'hFEFE, 16'hFEFF, 16'hFF60, 16'hFF61, 16'hFFFF
	};

	text_column_width_and_elide #(.MAX_UNITS(MAX_UNITS)) dut (.*);

	text_width_checker #(.MAX_UNITS(MAX_UNITS)) checker_i (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
		end
		$display("[text_column_width_and_elide] ERROR");
		$finish;
	end

	task automatic send_unit(input logic [tcw_pkg::CU_W-1:0] cu, input logic is_last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= cu;
		last <= is_last;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_text();
		foreach (text_buf[i]) begin
			send_unit(text_buf[i], i == text_buf.size() - 1);
		end
	endtask

	task automatic send_run(input logic [tcw_pkg::CU_W-1:0] cu, input int count,
		input logic ends_string);
		for (int i = 0; i < count; i++) begin
			send_unit(cu, ends_string && (i == count - 1));
		end
	endtask

	// wait until every report is out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max_width(input logic [tcw_pkg::MW_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [tcw_pkg::MW_W-1:0] pick_max_width();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			return 12'd0;
		end else if (pick < 20) begin
			return 12'd1;
		end else if (pick < 30) begin
			return 12'd2;
		end else if (pick < 40) begin
			return 12'd4095;
		end else if (pick < 45) begin
			return mw_t'($urandom_range(4095, 0));
		end
		return mw_t'($urandom_range(24, 3));
	endfunction

	task automatic build_random_text();
		int                       len;
		int                       pick;
		logic [tcw_pkg::CU_W-1:0] cu;
		logic [tcw_pkg::CU_W-1:0] hi;
		text_buf.delete();
		len = ($urandom_range(99) < 85) ? $urandom_range(10, 1) : $urandom_range(48, 11);
		while (text_buf.size() < len) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				cu = unit_t'($urandom_range(16'h7E, 16'h20));
			end else if (pick < 45) begin
				case ($urandom_range(3))
					0: cu = unit_t'($urandom_range(16'h9FFF, 16'h4E00));
					1: cu = unit_t'($urandom_range(16'hD7A3, 16'hAC00));
					2: cu = unit_t'($urandom_range(16'h33FF, 16'h3041));
					default: cu = unit_t'($urandom_range(16'hFF60, 16'hFF00));
				endcase
			end else if (pick < 52) begin
				case ($urandom_range(3))
					0: cu = unit_t'($urandom_range(16'h036F, 16'h0300));
					1: cu = unit_t'($urandom_range(16'h200F, 16'h200B));
					2: cu = unit_t'($urandom_range(16'hFE2F, 16'hFE00));
					default: cu = 16'hFEFF;
				endcase
			end else if (pick < 60) begin
				cu = edge_units[5'($urandom_range(23))];
			end else if (pick < 75) begin
				// pair, often landing in the wide supplementary blocks
				hi = ($urandom_range(1) != 0) ? unit_t'($urandom_range(16'hDBFF, 16'hD800))
					: (($urandom_range(1) != 0) ? 16'hD83C + unit_t'($urandom_range(2))
					: unit_t'($urandom_range(16'hD8BF, 16'hD840)));
				text_buf.push_back(hi);
				cu = unit_t'($urandom_range(16'hDFFF, 16'hDC00));
			end else if (pick < 80) begin
				cu = unit_t'($urandom_range(16'hDBFF, 16'hD800));
			end else if (pick < 85) begin
				cu = unit_t'($urandom_range(16'hDFFF, 16'hDC00));
			end else if (pick < 90) begin
				cu = 16'h0000;
			end else begin
				cu = unit_t'($urandom());
			end
			text_buf.push_back(cu);
		end
	endtask

	initial begin
		int sent;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at the reset width
		text_buf = '{16'h0041};
		send_text();
		text_buf = '{16'h0000};
		send_text();
		text_buf = '{16'hFFFF};
		send_text();
		text_buf = '{16'hD83D, 16'hDE00};
		send_text();
		text_buf = '{16'hDBFF};
		send_text();
		text_buf = '{16'hD800, 16'h0041};
		send_text();
		text_buf = '{16'hDFFF};
		send_text();
		text_buf = '{16'h0300, 16'hFEFF, 16'h200B};
		send_text();
		text_buf = '{16'h1100, 16'hAC00, 16'hFF60, 16'hD840, 16'hDC00, 16'hD8BF, 16'hDFFD};
		send_text();
		set_max_width(12'd0);
		text_buf = '{16'h0041};
		send_text();
		set_max_width(12'd1);
		text_buf = '{16'h0041, 16'h0042};
		send_text();
		set_max_width(12'd2);
		text_buf = '{16'h4E00, 16'h0041};
		send_text();
		set_max_width(12'd4095);
		text_buf = '{16'h0041};
		send_text();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					idle_pct = 10;
					stall_pct = 53;
				end
				1: begin
					idle_pct = 53;
					stall_pct = 10;
				end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < 340) begin
				if ($urandom_range(99) < 30) begin
					set_max_width(pick_max_width());
				end
				build_random_text();
				sent += text_buf.size();
				send_text();
			end
		end

		// long strings against a narrow width
		set_max_width(12'd24);
		send_run(16'h4E00, 40, 1'b1);
		send_run(16'h0000, 30, 1'b0);
		send_run(16'h0041, 30, 1'b1);
		settle();

		if (mismatch_count == 0 && reports_due == 0) begin
			$display("[text_column_width_and_elide] OK");
		end else begin
			$display("[text_column_width_and_elide] ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_column_width_and_elide.sv
tb/text_width_checker.sv
tb/text_column_width_and_elide_tb.sv
